### design/pcvt_pkg.sv
`timescale 1ns / 1ps

package pcvt_pkg;

  // pc arithmetic width, 32 to 64
  localparam int unsigned PcWidth = 64;

  // varint accumulator and shift counter
  localparam int unsigned AccWidth = 32;
  localparam int unsigned ShiftWidth = 6;
  localparam logic [ShiftWidth-1:0] ShiftStep = ShiftWidth'(7);
  localparam logic [ShiftWidth-1:0] ShiftCap = ShiftWidth'(35);

  // result queue
  localparam int unsigned ResDepth = 3;
  localparam int unsigned ResPtrWidth = 2;
  localparam int unsigned ResCntWidth = 2;

  // result status codes
  localparam logic StatusFound = 1'b0;
  localparam logic StatusEnd = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgQuantum  = 2'd0,
    CfgEntryPc  = 2'd1,
    CfgTargetPc = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] table_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] found_value;
  } res_item_t;

endpackage

### design/pcvt_rfifo.sv
`timescale 1ns / 1ps

module pcvt_rfifo import pcvt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  res_item_t              push_data_i,
  input  logic                   pop_i,
  output logic                   valid_o,
  output res_item_t              data_o,
  output logic [ResCntWidth-1:0] count_o
);

  res_item_t                mem_q [ResDepth];
  logic [ResPtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [ResPtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ResCntWidth-1:0]   cnt_q, cnt_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == ResPtrWidth'(ResDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == ResPtrWidth'(ResDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

### design/pc_value_table_decoder.sv
`timescale 1ns / 1ps

// pc-value table decoder
// input channel: in_valid_i / in_stall_o / in_data_i carries one table byte per
// transfer; restart set marks the first byte of a new table and reloads the pc
// from entry_pc and the value to -1
// output channel: out_valid_o / out_stall_i / out_data_o carries at most one
// result per table: the value at target_pc (status 0) or -1 at table end (status 1)
// configuration: cfg_we_i writes quantum (0), entry_pc (1) or target_pc (2)
// from cfg_wdata_i; write only while no table byte is in flight
// throughput: one byte per cycle while in_stall_o is low; a finished pair's pc
// update (pc add, target compare) runs in the cycle after its last byte
// a table-end result enters the queue as its byte is taken; a target hit is held
// as a pending pc update (pend_q, prod_q) and enters the queue from there
// results wait in a three-entry queue; when the receiver stalls, in_stall_o
// rises once the queue could not take the results still in flight
// reset clears the decoder (pc 0, value -1), quantum 1, entry and target 0
// bytes after a result are dropped until the next restart

module pc_value_table_decoder import pcvt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output res_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  // configuration registers
  logic [7:0]  quantum_q;
  logic [63:0] entry_q;
  logic [63:0] target_q;

  // decoder state
  logic                  in_pc_q, in_pc_d;
  logic [AccWidth-1:0]   acc_q, acc_d;
  logic [ShiftWidth-1:0] sh_q, sh_d;
  logic [31:0]           pdelta_q, pdelta_d;
  logic [PcWidth-1:0]    pc_q, pc_d;
  logic [31:0]           val_q, val_d;
  logic                  fin_q, fin_d;
  logic                  pend_q, pend_d;
  logic [31:0]           prod_q, prod_d;

  logic                  in_acc;
  logic [PcWidth-1:0]    entry_m, target_m;
  logic [PcWidth-1:0]    pc_eff, pc_base;
  logic [31:0]           val_eff, val_base;
  logic                  hit, fin_base, in_pc_base;
  logic [AccWidth-1:0]   acc_base, word;
  logic [ShiftWidth-1:0] sh_base;
  logic                  end_emit;
  logic                  res_push;
  res_item_t             res_data;
  logic [ResCntWidth-1:0] fifo_cnt;

  assign entry_m  = entry_q[PcWidth-1:0];
  assign target_m = target_q[PcWidth-1:0];

  // hold back input when the queue could not take every result in flight
  assign in_stall_o = (({1'b0, fifo_cnt} + {{ResCntWidth{1'b0}}, pend_q})
                      > (ResCntWidth + 1)'(ResDepth - 1));
  assign in_acc = in_valid_i && !in_stall_o;

  // finish the pc update of the last pair and test the target
  assign pc_eff  = pend_q ? pc_q + PcWidth'(prod_q) : pc_q;
  assign val_eff = pend_q ? val_q + pdelta_q : val_q;
  assign hit     = pend_q && (target_m < pc_eff);

  // byte decode
  always_comb begin
    pc_base    = pc_eff;
    val_base   = val_eff;
    fin_base   = fin_q || hit;
    in_pc_base = in_pc_q;
    acc_base   = acc_q;
    sh_base    = sh_q;
    if (in_acc && in_data_i.restart) begin
      pc_base    = entry_m;
      val_base   = '1;
      fin_base   = 1'b0;
      in_pc_base = 1'b0;
      acc_base   = '0;
      sh_base    = '0;
    end

    pc_d     = pc_base;
    val_d    = val_base;
    fin_d    = fin_base;
    in_pc_d  = in_pc_base;
    acc_d    = acc_base;
    sh_d     = sh_base;
    pdelta_d = pdelta_q;
    prod_d   = prod_q;
    pend_d   = 1'b0;
    end_emit = 1'b0;

    // payload bits at 32 and above are dropped
    word = acc_base;
    if (sh_base < ShiftWidth'(AccWidth)) begin
      word = acc_base | (AccWidth'(in_data_i.table_byte[6:0]) << sh_base);
    end

    if (in_acc && !fin_base) begin
      if (in_data_i.table_byte[7]) begin
        acc_d = word;
        sh_d  = (sh_base > ShiftCap - ShiftStep) ? ShiftCap : sh_base + ShiftStep;
      end else begin
        acc_d = '0;
        sh_d  = '0;
        if (!in_pc_base) begin
          if (word == '0 && pc_base != entry_m) begin
            end_emit = 1'b1;
            fin_d    = 1'b1;
          end else begin
            pdelta_d = word[0] ? ~(word >> 1) : (word >> 1);
            in_pc_d  = 1'b1;
          end
        end else begin
          prod_d  = word * AccWidth'(quantum_q);
          pend_d  = 1'b1;
          in_pc_d = 1'b0;
        end
      end
    end
  end

  // result selection
  assign res_push = hit || end_emit;
  always_comb begin
    res_data.status      = hit ? StatusFound : StatusEnd;
    res_data.found_value = hit ? val_eff : '1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pc_q  <= 1'b0;
      acc_q    <= '0;
      sh_q     <= '0;
      pdelta_q <= '0;
      pc_q     <= '0;
      val_q    <= '1;
      fin_q    <= 1'b0;
      pend_q   <= 1'b0;
      prod_q   <= '0;
    end else begin
      in_pc_q  <= in_pc_d;
      acc_q    <= acc_d;
      sh_q     <= sh_d;
      pdelta_q <= pdelta_d;
      pc_q     <= pc_d;
      val_q    <= val_d;
      fin_q    <= fin_d;
      pend_q   <= pend_d;
      prod_q   <= prod_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= 8'd1;
      entry_q   <= '0;
      target_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgQuantum:  quantum_q <= cfg_wdata_i[7:0];
        CfgEntryPc:  entry_q   <= cfg_wdata_i;
        CfgTargetPc: target_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // result queue
  pcvt_rfifo u_rfifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res_data),
    .pop_i       (out_valid_o && !out_stall_i),
    .valid_o     (out_valid_o),
    .data_o      (out_data_o),
    .count_o     (fifo_cnt)
  );

`ifndef ASSERT_OFF
  // a pending pc update always leaves the decoder on a value delta
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> !in_pc_q)
    else $error("pending pc update while reading a pc delta");

  // the queue never takes a result when full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (fifo_cnt != ResCntWidth'(ResDepth)))
    else $error("result queue overflow");

  // a result closes the table unless a restart arrives with it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && !(in_acc && in_data_i.restart)) |=> fin_q)
    else $error("decoder not finished after a result");

  // the shift counter stays on whole varint groups
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sh_q == 6'd0) || (sh_q == 6'd7) || (sh_q == 6'd14) || (sh_q == 6'd21) ||
    (sh_q == 6'd28) || (sh_q == 6'd35))
    else $error("varint shift off grid");
`endif

endmodule
